### rtl/core/olief_pkg.sv
// ----------------------------------------------------------------------------
// olief_pkg: shared definitions for the ordered list block
// Operation and status codes, field widths, and the command/status structs
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package olief_pkg;

  // Field widths of the request and response channels
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 7;

  // Default sizing
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Operation class seen by the controller
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INS,
    KIND_ERA,
    KIND_FIND
  } kind_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;     // capture request payload
    logic check;    // range/full/empty check, set up walk pointer
    logic rd;       // issue memory read for the current step
    logic shift;    // write read data at pointer, step pointer
    logic put_new;  // write new value at pointer, count up
    logic dec;      // count down (erase done)
    logic miss;     // find ran off the end
    logic hit;      // find matched at pointer
    logic adv;      // find: next entry
    logic publish;  // load response register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    kind_e kind;
    logic  pre_err;   // check failed, nothing to walk
    logic  walk_end;  // pointer reached its end point
    logic  match;     // read data equals search value
  } sts_t;

endpackage

### rtl/core/olief_req_if.sv
// ----------------------------------------------------------------------------
// olief_req_if: request channel of the ordered list block
// Valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface olief_req_if;
  logic                               valid;
  logic                               ready;
  logic [olief_pkg::MODE_W-1:0]       mode;
  logic [olief_pkg::POS_W-1:0]        position;
  logic signed [olief_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

### rtl/core/olief_rsp_if.sv
// ----------------------------------------------------------------------------
// olief_rsp_if: response channel of the ordered list block
// Valid/ready handshake carrying status, found index and entry count.
// ----------------------------------------------------------------------------
interface olief_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [olief_pkg::STATUS_W-1:0] status;
  logic [olief_pkg::IDX_W-1:0]    found_index;
  logic [olief_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

### rtl/core/olief_dp.sv
// ----------------------------------------------------------------------------
// olief_dp: datapath of the ordered list block
// Entry memory, count, walk pointer, checks and the response register.
// ----------------------------------------------------------------------------
module olief_dp #(
  parameter int unsigned DEPTH      = olief_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = olief_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  olief_pkg::cmd_t                       cmd_i,
  output olief_pkg::sts_t                       sts_o,
  input  logic [olief_pkg::MODE_W-1:0]          mode_i,
  input  logic [olief_pkg::POS_W-1:0]           position_i,
  input  logic signed [olief_pkg::VALUE_W-1:0]  value_i,
  output logic [olief_pkg::STATUS_W-1:0]        status_o,
  output logic [olief_pkg::IDX_W-1:0]           found_index_o,
  output logic [olief_pkg::CNT_W-1:0]           entry_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > olief_pkg::POS_W) ? CW : olief_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [olief_pkg::MODE_W-1:0]   mode_q;
  logic [olief_pkg::POS_W-1:0]    pos_q;
  logic [DATA_WIDTH-1:0]          val_q;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [CW-1:0]                  ptr_q, ptr_d;
  logic [CW-1:0]                  at_q;
  logic [DATA_WIDTH-1:0]          rd_q;
  logic [olief_pkg::STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [olief_pkg::STATUS_W-1:0] out_status_q;
  logic [AW-1:0]                  out_idx_q;
  logic [CW-1:0]                  out_cnt_q;

  olief_pkg::kind_e               kind;
  logic [LW-1:0]                  pos_l, cnt_l, at_l;
  logic [olief_pkg::STATUS_W-1:0] pre_status;
  logic [CW-1:0]                  ptr_init;
  logic [CW-1:0]                  rd_ptr;
  logic                           wr_en;
  logic [DATA_WIDTH-1:0]          wr_data;

  // Decode mode into class and effective position
  always_comb begin
    pos_l = LW'(pos_q);
    cnt_l = LW'(cnt_q);
    kind  = olief_pkg::KIND_NONE;
    at_l  = '0;
    case (mode_q)
      olief_pkg::MODE_INSERT: begin
        kind = olief_pkg::KIND_INS;
        at_l = pos_l;
      end
      olief_pkg::MODE_PUSH_BACK: begin
        kind = olief_pkg::KIND_INS;
        at_l = cnt_l;
      end
      olief_pkg::MODE_PUSH_FRONT: begin
        kind = olief_pkg::KIND_INS;
      end
      olief_pkg::MODE_ERASE: begin
        kind = olief_pkg::KIND_ERA;
        at_l = pos_l;
      end
      olief_pkg::MODE_POP_BACK: begin
        kind = olief_pkg::KIND_ERA;
        at_l = cnt_l - LW'(1);
      end
      olief_pkg::MODE_POP_FRONT: begin
        kind = olief_pkg::KIND_ERA;
      end
      olief_pkg::MODE_FIND: begin
        kind = olief_pkg::KIND_FIND;
      end
      default: begin
        kind = olief_pkg::KIND_NONE;
      end
    endcase
  end

  // Checks: position before full for insert, empty before position for erase
  always_comb begin
    pre_status = olief_pkg::ST_OK;
    ptr_init   = '0;
    case (kind)
      olief_pkg::KIND_INS: begin
        ptr_init = cnt_q;
        if (at_l > cnt_l) begin
          pre_status = olief_pkg::ST_BADPOS;
        end else if (cnt_q == CW'(DEPTH)) begin
          pre_status = olief_pkg::ST_FULL;
        end
      end
      olief_pkg::KIND_ERA: begin
        ptr_init = at_l[CW-1:0];
        if (cnt_q == '0) begin
          pre_status = olief_pkg::ST_EMPTY;
        end else if (at_l >= cnt_l) begin
          pre_status = olief_pkg::ST_BADPOS;
        end
      end
      default: begin
        ptr_init = '0;
      end
    endcase
  end

  // Walk end point and read address per class
  always_comb begin
    sts_o.kind     = kind;
    sts_o.pre_err  = (pre_status != olief_pkg::ST_OK);
    sts_o.match    = (rd_q == val_q);
    sts_o.walk_end = 1'b0;
    rd_ptr         = ptr_q;
    case (kind)
      olief_pkg::KIND_INS: begin
        sts_o.walk_end = (ptr_q == at_q);
        rd_ptr         = ptr_q - CW'(1);
      end
      olief_pkg::KIND_ERA: begin
        sts_o.walk_end = ((ptr_q + CW'(1)) == cnt_q);
        rd_ptr         = ptr_q + CW'(1);
      end
      olief_pkg::KIND_FIND: begin
        sts_o.walk_end = (ptr_q == cnt_q);
      end
      default: begin
        sts_o.walk_end = 1'b1;
      end
    endcase
  end

  // Pointer, count, result update
  always_comb begin
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    idx_d    = idx_q;
    if (cmd_i.check) begin
      ptr_d    = ptr_init;
      status_d = pre_status;
      idx_d    = '0;
    end
    if (cmd_i.shift) begin
      ptr_d = (kind == olief_pkg::KIND_INS) ? ptr_q - CW'(1) : ptr_q + CW'(1);
    end
    if (cmd_i.adv) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (cmd_i.put_new) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.miss) begin
      status_d = olief_pkg::ST_NOTFOUND;
    end
    if (cmd_i.hit) begin
      idx_d = ptr_q[AW-1:0];
    end
  end

  assign wr_en   = cmd_i.shift | cmd_i.put_new;
  assign wr_data = cmd_i.put_new ? val_q : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= DATA_WIDTH'($unsigned(value_i));
    end
    ptr_q    <= ptr_d;
    at_q     <= cmd_i.check ? at_l[CW-1:0] : at_q;
    status_q <= status_d;
    idx_q    <= idx_d;
    if (cmd_i.publish) begin
      out_status_q <= status_q;
      out_idx_q    <= idx_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ptr_q[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign status_o      = out_status_q;
  assign found_index_o = olief_pkg::IDX_W'(out_idx_q);
  assign entry_count_o = olief_pkg::CNT_W'(out_cnt_q);

endmodule

### rtl/core/olief_ctrl.sv
// ----------------------------------------------------------------------------
// olief_ctrl: controller of the ordered list block
// Sequences check, shift/search walk and response hand-off.
// ----------------------------------------------------------------------------
module olief_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  olief_pkg::sts_t sts_i,
  output olief_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.pre_err || (sts_i.kind == olief_pkg::KIND_NONE)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          case (sts_i.kind)
            olief_pkg::KIND_INS:  cmd_o.put_new = 1'b1;
            olief_pkg::KIND_ERA:  cmd_o.dec     = 1'b1;
            olief_pkg::KIND_FIND: cmd_o.miss    = 1'b1;
            default:              cmd_o.miss    = 1'b0;
          endcase
          state_d = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = (sts_i.kind == olief_pkg::KIND_FIND) ? S_CMP : S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_WALK;
      end
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_FIN;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_WALK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    if (cmd_o.publish) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

### rtl/core/ordered_list_insert_erase_find.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find: ordered list with positional insert/erase
// Keeps up to DEPTH values in order plus a count; insert, erase, push, pop
// and find, one request at a time, one response per request.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req_i: one list operation per request (mode, position, value).
//    Taken only while the block is idle; ready drops while it works.
//  - rsp_o: one response per request: status, found index, count after op.
//  - Sequence: each request is loaded, then checked; a rejected request or
//    an unused mode goes straight to the response. Insert/erase then move
//    entries one at a time (memory read, then write), and find scans
//    entries one at a time (read, compare), stopping early on a hit. A new
//    request is taken the cycle after the response is loaded, so the block
//    finishes one request before it takes the next.
//  - The entry memory has one write port and one registered read port;
//    one entry moves per read/write pair.
//  - Reset clears the count and the response valid; entry storage is not
//    cleared, entries at or above the count are never read.
//  - If the receiver stalls, the response register holds; the next request
//    is still accepted and processed, and waits at the end for the
//    response register to empty.
// ----------------------------------------------------------------------------
module ordered_list_insert_erase_find #(
  parameter int unsigned DEPTH      = olief_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = olief_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  olief_req_if.sink   req_i,
  olief_rsp_if.source rsp_o
);

  olief_pkg::cmd_t cmd;
  olief_pkg::sts_t sts;

  // Sequencer: owns handshakes and step order
  olief_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, count, walk pointer and response payload
  olief_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (req_i.mode),
    .position_i    (req_i.position),
    .value_i       (req_i.value),
    .status_o      (rsp_o.status),
    .found_index_o (rsp_o.found_index),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule

### sim/tb_ordered_list_insert_erase_find.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_erase_find: self-checking bench for the ordered list
// Drives list operations over the request channel. A shadow copy of the list
// predicts status, found index and count for each request, and the response
// monitor checks them in order while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_erase_find;
  import olief_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int DATA_WIDTH = DATA_WIDTH_DEF;

  // mode 7 has no package name; the block must treat it as a no-op
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // Worst case op: find that misses on a full list
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int RANDOM_OPS   = 1880;
  localparam int IDLE_PCT     = 36;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    logic [CNT_W-1:0]    entry_count;
  } list_rsp_t;

  // Random part cycles through phases so the list swings between empty and full
  typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_MIX} mood_e;

  logic clk_i;
  logic rst_ni;

  olief_req_if req_if ();
  olief_rsp_if rsp_if ();

  ordered_list_insert_erase_find #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // --------------------------------------------------------------------------
  // Shadow list: updated at the edge that accepts each request
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] shadow_list [DEPTH];
  int                    shadow_len = 0;

  list_req_t pending_ops [$];   // requests waiting for the driver
  list_rsp_t expected_rsp [$];  // predicted responses, oldest first
  int        n_fail = 0;
  bit        calm   = 1'b0;     // no stalls on either side while set

  function automatic logic [STATUS_W-1:0] shadow_insert(int at, logic [DATA_WIDTH-1:0] v);
    // position check wins over the full check
    if (at > shadow_len) return ST_BADPOS;
    if (shadow_len >= DEPTH) return ST_FULL;
    for (int k = shadow_len; k > at; k--) shadow_list[k] = shadow_list[k-1];
    shadow_list[at] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] shadow_erase(int at);
    if (shadow_len == 0) return ST_EMPTY;
    if (at >= shadow_len) return ST_BADPOS;
    for (int k = at; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
    shadow_len--;
    return ST_OK;
  endfunction

  function automatic list_rsp_t predict_list_op(list_req_t op);
    list_rsp_t             r;
    logic [DATA_WIDTH-1:0] v;
    v             = op.value[DATA_WIDTH-1:0];
    r.status      = ST_OK;
    r.found_index = '0;
    case (op.mode)
      MODE_INSERT:     r.status = shadow_insert(int'(op.position), v);
      MODE_ERASE:      r.status = shadow_erase(int'(op.position));
      MODE_FIND: begin
        // first match wins, duplicates are expected
        r.status = ST_NOTFOUND;
        for (int k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] == v) begin
            r.status      = ST_OK;
            r.found_index = IDX_W'(k);
            break;
          end
        end
      end
      MODE_PUSH_BACK:  r.status = shadow_insert(shadow_len, v);
      MODE_POP_BACK:   r.status = (shadow_len == 0) ? ST_EMPTY : shadow_erase(shadow_len - 1);
      MODE_PUSH_FRONT: r.status = shadow_insert(0, v);
      MODE_POP_FRONT:  r.status = shadow_erase(0);
      default: ;       // unused mode: nothing changes, status ok
    endcase
    r.entry_count = CNT_W'(shadow_len);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Values lean on a small pool so duplicates and the signed extremes show up
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return VALUE_W'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Built against the shadow list as it stands; a request or two may still be
  // in flight, so a few positions turn out stale, which is wanted noise too.
  function automatic list_req_t random_op(mood_e mood);
    list_req_t op;
    int        len;
    int        r;
    int        ins_pct;
    int        del_pct;
    len      = shadow_len;
    r        = $urandom_range(99);
    ins_pct  = (mood == MOOD_GROW) ? 60 : (mood == MOOD_SHRINK) ? 20 : 38;
    del_pct  = (mood == MOOD_GROW) ? 18 : (mood == MOOD_SHRINK) ? 58 : 38;
    op.value    = pick_value();
    op.position = POS_W'($urandom_range(DEPTH));   // ignored by most modes
    if (r < ins_pct) begin
      case ($urandom_range(3))
        0, 1: begin
          op.mode     = MODE_INSERT;
          op.position = POS_W'(($urandom_range(9) == 0) ? $urandom_range(DEPTH)
                                                        : $urandom_range(len));
        end
        2:       op.mode = MODE_PUSH_BACK;
        default: op.mode = MODE_PUSH_FRONT;
      endcase
    end else if (r < ins_pct + del_pct) begin
      case ($urandom_range(3))
        0, 1: begin
          op.mode     = MODE_ERASE;
          op.position = POS_W'((len == 0 || $urandom_range(9) == 0) ? $urandom_range(DEPTH)
                                                                     : $urandom_range(len - 1));
        end
        2:       op.mode = MODE_POP_BACK;
        default: op.mode = MODE_POP_FRONT;
      endcase
    end else if (r < 97) begin
      op.mode = MODE_FIND;
      // mostly search for something stored, else likely a miss
      if (len > 0 && $urandom_range(9) < 6) op.value = shadow_list[$urandom_range(len - 1)];
    end else begin
      op.mode = MODE_UNUSED;
    end
    return op;
  endfunction

  // Keep at most one request queued ahead of the driver
  task automatic queue_op(logic [MODE_W-1:0] mode, int pos, logic signed [VALUE_W-1:0] value);
    list_req_t op;
    op.mode     = mode;
    op.position = POS_W'(pos);
    op.value    = value;
    while (pending_ops.size() != 0) @(posedge clk_i);
    pending_ops.push_back(op);
  endtask

  function automatic bit list_busy();
    return pending_ops.size() != 0 || req_if.valid || expected_rsp.size() != 0;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request driver: predicts on acceptance, then offers the next request.
  // valid gets at most one NBA per edge so a held request never glitches.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    list_req_t nxt;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.mode     <= '0;
      req_if.position <= '0;
      req_if.value    <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        nxt.mode     = req_if.mode;
        nxt.position = req_if.position;
        nxt.value    = req_if.value;
        expected_rsp.push_back(predict_list_op(nxt));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_ops.pop_front();
          req_if.valid    <= 1'b1;
          req_if.mode     <= nxt.mode;
          req_if.position <= nxt.position;
          req_if.value    <= nxt.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: random backpressure, in-order field compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_responses
    list_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: status %0d count %0d",
                 rsp_if.status, rsp_if.entry_count);
          n_fail++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            n_fail++;
          end
          if (rsp_if.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, rsp_if.found_index);
            n_fail++;
          end
          if (rsp_if.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_if.entry_count);
            n_fail++;
          end
        end
      end
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed corners, random phases, drain, verdict
  // --------------------------------------------------------------------------
  initial begin : run_sequence
    mood_e mood;
    // known levels before the first edge; the always blocks take over later
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every removal reports empty, find misses, insert past end
    queue_op(MODE_FIND,       0,  32'sd0);
    queue_op(MODE_POP_BACK,   0,  32'sd0);
    queue_op(MODE_POP_FRONT,  0,  32'sd0);
    queue_op(MODE_ERASE,      0,  32'sd0);
    queue_op(MODE_ERASE,      DEPTH, -32'sd1);
    queue_op(MODE_INSERT,     1,  32'sd5);
    // Build [-1, max, min, max, 0] with a duplicate for first-match find
    queue_op(MODE_INSERT,     0,  32'sh8000_0000);
    queue_op(MODE_PUSH_BACK,  0,  32'sh7fff_ffff);
    queue_op(MODE_PUSH_FRONT, DEPTH, -32'sd1);
    queue_op(MODE_INSERT,     3,  32'sd0);          // insert at the very end
    queue_op(MODE_INSERT,     1,  32'sh7fff_ffff);
    queue_op(MODE_FIND,       0,  32'sh7fff_ffff);
    queue_op(MODE_FIND,       0,  32'sh1234_5678);  // miss on a populated list
    queue_op(MODE_FIND,       0,  32'sh8000_0000);
    // Bad positions on a populated list
    queue_op(MODE_INSERT,     DEPTH, 32'sd9);
    queue_op(MODE_ERASE,      5,  32'sd0);          // erase at count
    queue_op(MODE_ERASE,      DEPTH, 32'sd0);
    queue_op(MODE_UNUSED,     DEPTH, -32'sd1);      // no-op mode
    queue_op(MODE_ERASE,      2,  32'sd0);
    queue_op(MODE_POP_BACK,   0,  32'sd0);
    queue_op(MODE_POP_FRONT,  0,  32'sd0);
    queue_op(MODE_FIND,       0,  -32'sd1);
    queue_op(MODE_ERASE,      0,  32'sd0);

    // Sender holds off until the block has answered everything
    while (list_busy()) @(posedge clk_i);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      case ((i / 160) % 4)
        0:       mood = MOOD_GROW;
        2:       mood = MOOD_SHRINK;
        default: mood = MOOD_MIX;
      endcase
      // one long stretch with back-to-back traffic on both sides
      calm = (i >= 800 && i < 1100);
      if (i == 1400) begin
        while (list_busy()) @(posedge clk_i);
      end
      while (pending_ops.size() != 0) @(posedge clk_i);
      pending_ops.push_back(random_op(mood));
    end

    while (list_busy()) @(posedge clk_i);
    // any stray response would still show up in this window
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #2500000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
